>>> hw/rtl/ppt_pkg.sv
`timescale 1ns / 1ps

package ppt_pkg;

    // Field widths
    localparam int CW    = 32;            // coordinate width, signed Q16.16
    localparam int EW    = 32;            // matrix entry width, signed Q16.16
    localparam int FRAC  = 16;            // fraction bits
    localparam int PW    = EW + CW;       // entry times coordinate
    localparam int MW    = EW + CW;       // magnitude of a row sum
    localparam int SW    = PW + 2;        // signed row sum of four terms
    localparam int NROW  = 4;
    localparam int NREG  = 8;
    localparam int RW    = 2 * EW;        // one config register, two entries
    localparam int IW    = 8;             // config index width
    localparam int W_ROW = 3;             // row that gives homogeneous w

    // Quotient bounds
    localparam logic [CW-1:0] LIM_POS = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] LIM_NEG = {1'b1, {(CW-1){1'b0}}};

    typedef logic [NREG-1:0][RW-1:0] t_mat;

    // Identity matrix at reset
    localparam logic [RW-1:0] ONE_LO = RW'(1) << FRAC;
    localparam logic [RW-1:0] ONE_HI = RW'(1) << (EW + FRAC);
    localparam t_mat MAT_RESET = {ONE_HI, {RW{1'b0}}, ONE_LO, {RW{1'b0}},
                                  {RW{1'b0}}, ONE_HI, {RW{1'b0}}, ONE_LO};

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_point;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 w_zero;
        logic                 saturated;
    } t_result;

    // One row sum as sign and magnitude
    typedef struct packed {
        logic          neg;
        logic [MW-1:0] mag;
    } t_row;

    typedef t_row [NROW-1:0] t_rows;

    // Matrix entry M[row][col]; low column of a pair sits in the low half
    function automatic logic signed [EW-1:0] entry(t_mat m, logic [1:0] row,
                                                   logic [1:0] col);
        logic [RW-1:0] pair;
        pair = m[{row, col[1]}];
        return col[0] ? pair[RW-1:EW] : pair[EW-1:0];
    endfunction

endpackage

>>> hw/rtl/ppt_if.sv
`timescale 1ns / 1ps

// Point input channel
interface ppt_point_if import ppt_pkg::*; ();
    logic   valid;
    logic   ready;
    t_point data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// Projected result channel
interface ppt_result_if import ppt_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// Matrix register write channel
interface ppt_cfg_if import ppt_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [IW-1:0] index;
    logic [RW-1:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/ppt_dot.sv
`timescale 1ns / 1ps

// Four row dot products: multiply, two adder levels, sign/magnitude.
module ppt_dot import ppt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  t_mat   i_mat,
    input  logic   i_valid,
    input  t_point i_pt,
    output logic   o_valid,
    output t_rows  o_rows
);

    localparam int NS = 4;

    logic [NS-1:0]        r_v;
    logic signed [PW-1:0] r_prod [NROW][3];
    logic signed [PW-1:0] n_prod [NROW][3];
    logic signed [PW-1:0] r_ofs  [NROW];
    logic signed [PW-1:0] n_ofs  [NROW];
    logic signed [SW-1:0] r_sa   [NROW];
    logic signed [SW-1:0] n_sa   [NROW];
    logic signed [SW-1:0] r_sb   [NROW];
    logic signed [SW-1:0] n_sb   [NROW];
    logic signed [SW-1:0] r_sum  [NROW];
    logic signed [SW-1:0] n_sum  [NROW];
    t_rows                r_rows;
    t_rows                n_rows;
    logic signed [CW-1:0] pv     [3];

    assign pv[0] = i_pt.x;
    assign pv[1] = i_pt.y;
    assign pv[2] = i_pt.z;

    // Stage 1: products, column 3 scaled by the implied w of one
    always_comb begin
        for (int r = 0; r < NROW; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[r][c] = PW'(entry(i_mat, 2'(r), 2'(c))) * PW'(pv[c]);
            end
            n_ofs[r] = PW'(entry(i_mat, 2'(r), 2'd3)) <<< FRAC;
        end
    end

    // Stages 2 to 4: pair sums, full sum, magnitude
    always_comb begin
        for (int r = 0; r < NROW; r++) begin
            n_sa[r] = SW'(r_prod[r][0]) + SW'(r_prod[r][1]);
            n_sb[r] = SW'(r_prod[r][2]) + SW'(r_ofs[r]);
            n_sum[r] = r_sa[r] + r_sb[r];
            n_rows[r].neg = r_sum[r][SW-1];
            n_rows[r].mag = r_sum[r][SW-1] ? MW'(-r_sum[r]) : MW'(r_sum[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= n_prod;
            r_ofs  <= n_ofs;
            r_sa   <= n_sa;
            r_sb   <= n_sb;
            r_sum  <= n_sum;
            r_rows <= n_rows;
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_rows  = r_rows;

endmodule

>>> hw/rtl/ppt_div.sv
`timescale 1ns / 1ps

// Three restoring dividers in lockstep, one quotient bit per stage,
// then saturation and sign.
module ppt_div import ppt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  logic    i_valid,
    input  t_rows   i_rows,
    output logic    o_valid,
    output t_result o_res
);

    localparam int NS = CW + 2;

    typedef struct packed {
        logic [2:0][MW-1:0] rem;
        logic [2:0][CW-1:0] low;   // dividend bits not yet shifted in
        logic [2:0][CW-1:0] quo;
        logic [2:0]         ovf;   // quotient needs more than CW bits
        logic [2:0]         neg;
        logic [MW-1:0]      den;
        logic               wz;
    } t_dstage;

    logic [NS-1:0] r_v;
    t_dstage       r_st [CW+1];
    t_dstage       n_st [CW+1];
    t_result       r_res;
    t_result       n_res;
    logic [CW-1:0] outv [3];

    always_comb begin
        logic [MW-1:0] nm;
        logic [MW:0]   sh;
        logic          ge;
        // Stage 0: load numerators shifted by the fraction, check range
        n_st[0].den = i_rows[W_ROW].mag;
        n_st[0].wz  = (i_rows[W_ROW].mag == '0);
        for (int c = 0; c < 3; c++) begin
            nm = i_rows[c].mag;
            n_st[0].rem[c] = nm >> (CW - FRAC);
            n_st[0].ovf[c] = (nm >> (CW - FRAC)) >= i_rows[W_ROW].mag;
            n_st[0].low[c] = {nm[CW-FRAC-1:0], {FRAC{1'b0}}};
            n_st[0].quo[c] = '0;
            n_st[0].neg[c] = i_rows[c].neg ^ i_rows[W_ROW].neg;
        end
        // Stages 1..CW: shift in one dividend bit, trial subtract
        for (int s = 1; s <= CW; s++) begin
            n_st[s] = r_st[s-1];
            for (int c = 0; c < 3; c++) begin
                sh = {r_st[s-1].rem[c], r_st[s-1].low[c][CW-1]};
                ge = sh >= {1'b0, r_st[s-1].den};
                n_st[s].rem[c] = ge ? MW'(sh - {1'b0, r_st[s-1].den}) : MW'(sh);
                n_st[s].quo[c] = {r_st[s-1].quo[c][CW-2:0], ge};
                n_st[s].low[c] = r_st[s-1].low[c] << 1;
            end
        end
    end

    // Last stage: clamp to the signed range, apply sign, zero-w override
    always_comb begin
        logic [CW-1:0] lim;
        logic [CW-1:0] qq;
        logic          sat_c;
        logic          any;
        any = 1'b0;
        for (int c = 0; c < 3; c++) begin
            lim   = r_st[CW].neg[c] ? LIM_NEG : LIM_POS;
            sat_c = r_st[CW].ovf[c] || (r_st[CW].quo[c] > lim);
            qq    = sat_c ? lim : r_st[CW].quo[c];
            outv[c] = r_st[CW].neg[c] ? -qq : qq;
            any   = any | sat_c;
        end
        if (r_st[CW].wz) begin
            n_res.x         = '0;
            n_res.y         = '0;
            n_res.z         = '0;
            n_res.w_zero    = 1'b1;
            n_res.saturated = 1'b0;
        end else begin
            n_res.x         = outv[0];
            n_res.y         = outv[1];
            n_res.z         = outv[2];
            n_res.w_zero    = 1'b0;
            n_res.saturated = any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_st  <= n_st;
            r_res <= n_res;
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_res   = r_res;

    // A held pipeline keeps its occupancy
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_v))
        else $error("divider pipeline moved while held");

endmodule

>>> hw/rtl/ppt_obuf.sv
`timescale 1ns / 1ps

// Two-entry output buffer; lets the pipeline keep moving while a result waits.
module ppt_obuf import ppt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    localparam int DEPTH = 2;
    localparam int CNTW  = 2;

    t_result         r_mem [DEPTH];
    logic            r_wp;
    logic            r_rp;
    logic [CNTW-1:0] r_cnt;
    logic            push;
    logic            pop;

    assign o_valid = (r_cnt != '0);
    assign o_space = (r_cnt != CNTW'(DEPTH)) || i_ready;
    assign push    = i_valid && o_space;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> hw/rtl/projective_point_transform.sv
`timescale 1ns / 1ps

// Projective point transform with perspective divide.
// i_pt takes one signed Q16.16 point (x, y, z) per item; o_res gives one
// item per point: the point times the 4x4 matrix, divided by w, truncated
// toward zero and clamped to Q16.16, with w_zero and saturated flags.
// i_cfg writes the eight 64-bit matrix registers (index 0..7, higher indexes
// are dropped); it is always ready and should only be used while no point
// is in flight.
// Throughput: one item per cycle while i_pt.ready is high.
// Path to o_res.valid: 4 stages of multiply and add, 34 bit-per-stage
// divider stages with range check and clamp, one output buffer slot.
// Reset loads the identity matrix and empties the pipeline.
// When o_res stalls, results pile into a two-entry output buffer; the
// pipeline stops only once that buffer is full and a result sits at the
// pipeline's end, and then i_pt.ready drops. No item is lost or repeated.
module projective_point_transform import ppt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ppt_point_if.sink       i_pt,
    ppt_result_if.source    o_res,
    ppt_cfg_if.sink         i_cfg
);

    t_mat    r_mat;
    logic    adv;
    logic    obuf_space;
    logic    dot_valid;
    t_rows   dot_rows;
    logic    div_valid;
    t_result div_res;

    // Matrix registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= MAT_RESET;
        end else if (i_cfg.valid && (i_cfg.index < IW'(NREG))) begin
            r_mat[i_cfg.index[2:0]] <= i_cfg.data;
        end
    end

    // Whole pipeline moves unless a result at its end has nowhere to go
    assign adv        = obuf_space || !div_valid;
    assign i_pt.ready = adv;

    ppt_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_mat   (r_mat),
        .i_valid (i_pt.valid),
        .i_pt    (i_pt.data),
        .o_valid (dot_valid),
        .o_rows  (dot_rows)
    );

    ppt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (dot_valid),
        .i_rows  (dot_rows),
        .o_valid (div_valid),
        .o_res   (div_res)
    );

    ppt_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .i_data  (div_res),
        .o_space (obuf_space),
        .o_valid (o_res.valid),
        .o_data  (o_res.data),
        .i_ready (o_res.ready)
    );

    // Zero w gives a zero point and no clamp
    a_wzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.w_zero) |->
            (o_res.data.x == '0 && o_res.data.y == '0 && o_res.data.z == '0
             && !o_res.data.saturated))
        else $error("w_zero result not cleared");

    // A clamped result has a coordinate on a bound
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.saturated) |->
            (o_res.data.x == LIM_POS || o_res.data.x == LIM_NEG ||
             o_res.data.y == LIM_POS || o_res.data.y == LIM_NEG ||
             o_res.data.z == LIM_POS || o_res.data.z == LIM_NEG))
        else $error("saturated flag without clamped coordinate");

endmodule
